@@ rtl/nmc_pkg.sv @@
// shared constants, codes and controller/datapath interface types
`default_nettype none
package nmc_pkg;
	localparam int KERNEL_SIZE = 3;
	localparam int MAX_SIZE    = 256;
	localparam int CENTRE      = (KERNEL_SIZE - 1) / 2;
	localparam int BACK        = KERNEL_SIZE - 1 - CENTRE;
	localparam int LINE_SLOTS  = 2 * KERNEL_SIZE;
	localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
	localparam int DEPTH       = LINE_SLOTS * MAX_SIZE;

	localparam int SAMPLE_W  = 16;
	localparam int WEIGHT_W  = 8;
	localparam int POS_W     = $clog2(MAX_SIZE + 1);
	localparam int SLOT_W    = $clog2(LINE_SLOTS);
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int TAP_W     = $clog2(TAPS + 1);
	localparam int KIDX_W    = $clog2(KERNEL_SIZE + 1);
	localparam int WSUM_W    = WEIGHT_W + $clog2(TAPS) + 1;
	localparam int ACC_W     = SAMPLE_W + WEIGHT_W + $clog2(TAPS) + 1;
	localparam int CNT_W     = $clog2(MAX_SIZE * MAX_SIZE + 1);
	localparam int DIVC_W    = $clog2(ACC_W + 1);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;
	localparam int SIZE_W    = 9;
	localparam int COEF_WORDS = 4;

	localparam logic [CFG_IDX_W-1:0] REG_COEF0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 3'd7;

	localparam logic [1:0] MODE_ZERO = 2'd1;
	localparam logic [1:0] MODE_PASS = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CTR_RD,
		ST_CTR_CHK,
		ST_TAP_RD,
		ST_TAP_ACC,
		ST_DIV_INIT,
		ST_DIV,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd_ctr;
		logic chk_ctr;
		logic tap_rd;
		logic tap_acc;
		logic div_start;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic emit_req;
		logic skip;
		logic tap_last;
		logic div_last;
		logic out_free;
	} stat_t;
endpackage
`default_nettype wire

@@ rtl/normalized_masked_convolution.sv @@
// top level: normalized masked KxK convolution over a raster pixel stream
// a beat that releases a pixel starts a centre read, a K*K tap walk with a read and an
//   accumulate state per tap, a restoring divide at one quotient bit per cycle and a load
//   into the output register; an out-of-range centre in a restricted mode skips walk and
//   divide; other beats emit nothing; no beat is taken until the result is loaded
// reset: arst_n clears positions, pending count, output valid; config to defaults; line store is kept
`default_nettype none
module normalized_masked_convolution (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write port
	input  wire logic                             cfg_we,
	input  wire logic [nmc_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  wire logic [nmc_pkg::CFG_W-1:0]        cfg_wdata,
	// input beat
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             opcode,
	input  wire logic signed [nmc_pkg::SAMPLE_W-1:0] sample,
	// result beat
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [nmc_pkg::SAMPLE_W-1:0]   result,
	output logic                                  no_weight,
	output logic                                  last_pixel
);
	import nmc_pkg::*;

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	// sequencer: accept, centre read, window walk, divide, hand off to output register
	nmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: line store ring of 2K rows, tap accumulator, divider, output register
	// the output register lets a new beat in while a result still waits downstream
	nmc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.opcode     (opcode),
		.sample     (sample),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.result     (result),
		.no_weight  (no_weight),
		.last_pixel (last_pixel),
		.cmd        (cmd),
		.stat       (stat)
	);
endmodule
`default_nettype wire

@@ rtl/nmc_ram.sv @@
// generic single-port-write, registered-read ram
`default_nettype none
module nmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/nmc_ctrl.sv @@
// sequencing state machine for one beat
`default_nettype none
module nmc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire nmc_pkg::stat_t stat,
	output nmc_pkg::cmd_t       cmd
);
	import nmc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.emit_req) state_d = ST_CTR_RD;
				end
			end
			ST_CTR_RD: begin
				cmd.rd_ctr = 1'b1;
				state_d    = ST_CTR_CHK;
			end
			ST_CTR_CHK: begin
				cmd.chk_ctr = 1'b1;
				state_d     = stat.skip ? ST_HOLD : ST_TAP_RD;
			end
			ST_TAP_RD: begin
				cmd.tap_rd = 1'b1;
				state_d    = ST_TAP_ACC;
			end
			ST_TAP_ACC: begin
				cmd.tap_acc = 1'b1;
				state_d     = stat.tap_last ? ST_DIV_INIT : ST_TAP_RD;
			end
			ST_DIV_INIT: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/nmc_dp.sv @@
// datapath: config registers, positions, line store, accumulator, divider, output register
`default_nettype none
module nmc_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [nmc_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  wire logic [nmc_pkg::CFG_W-1:0]        cfg_wdata,
	input  wire logic                             opcode,
	input  wire logic signed [nmc_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                             out_ready,
	output logic                                  out_valid,
	output logic signed [nmc_pkg::SAMPLE_W-1:0]   result,
	output logic                                  no_weight,
	output logic                                  last_pixel,
	input  wire nmc_pkg::cmd_t                    cmd,
	output nmc_pkg::stat_t                        stat
);
	import nmc_pkg::*;

	logic [CFG_W-1:0]           coef_q [COEF_WORDS];
	logic [1:0]                 mode_q;
	logic signed [SAMPLE_W-1:0] lower_q, upper_q;
	logic [SIZE_W-1:0]          size_q;
	logic [POS_W-1:0]           n_c;
	logic [CNT_W-1:0]           nn_c, lag_c;

	logic [POS_W-1:0]  in_col_q, out_col_q, out_row_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic [CNT_W-1:0]  out_idx_q, pending_q;

	logic [KIDX_W-1:0] k_q, l_q;
	logic [TAP_W-1:0]  t_q;
	logic              tap_ok_q;
	logic [WEIGHT_W-1:0] tap_w_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [WSUM_W-1:0] wsum_q;
	logic signed [SAMPLE_W-1:0] centre_q;
	logic              skip_q;

	logic [ACC_W-1:0]  mag_q;
	logic [WSUM_W:0]   rem_q;
	logic [DIVC_W-1:0] divc_q;
	logic              neg_q;

	logic                       ram_we;
	logic [ADDR_W-1:0]          waddr, raddr;
	logic signed [SAMPLE_W-1:0] rdata;

	// effective size, clamped to 1..MAX_SIZE
	always_comb begin
		if (size_q == '0) n_c = POS_W'(1);
		else if (size_q > SIZE_W'(MAX_SIZE)) n_c = POS_W'(MAX_SIZE);
		else n_c = POS_W'(size_q);
	end

	// pixels per image and output lag follow the size at once
	assign nn_c  = CNT_W'(n_c) * CNT_W'(n_c);
	assign lag_c = CNT_W'(n_c) * CNT_W'(CENTRE) + CNT_W'(CENTRE);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_WORDS; i++) coef_q[i] <= '0;
			mode_q  <= '0;
			lower_q <= -16'sd32768;
			upper_q <= 16'sd32767;
			size_q  <= SIZE_W'(256);
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_COEF0: coef_q[0] <= cfg_wdata;
					REG_COEF1: coef_q[1] <= cfg_wdata;
					REG_COEF2: coef_q[2] <= cfg_wdata;
					REG_COEF3: coef_q[3] <= cfg_wdata;
					REG_MODE:  mode_q    <= cfg_wdata[1:0];
					REG_LOWER: lower_q   <= cfg_wdata[SAMPLE_W-1:0];
					REG_UPPER: upper_q   <= cfg_wdata[SAMPLE_W-1:0];
					REG_SIZE:  size_q    <= cfg_wdata[SIZE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// emit decision for the beat at the input
	logic [CNT_W:0] pend_next, span;
	logic           emit_req_c;
	always_comb begin
		pend_next = {1'b0, pending_q} + 1'b1;
		span      = {1'b0, out_idx_q} + {1'b0, pending_q};
		if (opcode == OP_SAMPLE) emit_req_c = pend_next > {1'b0, lag_c};
		else emit_req_c = (pending_q != '0) && (span >= {1'b0, nn_c});
	end

	// positions
	wire restart = cfg_we && (cfg_addr == REG_SIZE);
	wire smp_acc = cmd.accept && (opcode == OP_SAMPLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			out_idx_q  <= '0;
			pending_q  <= '0;
		end else if (restart) begin
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			out_idx_q  <= '0;
			pending_q  <= '0;
		end else begin
			if (smp_acc) begin
				pending_q <= pending_q + 1'b1;
				if (in_col_q + 1'b1 >= n_c) begin
					in_col_q  <= '0;
					in_slot_q <= (in_slot_q == SLOT_W'(LINE_SLOTS - 1)) ? '0 : in_slot_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (cmd.load_out) begin
				pending_q <= pending_q - 1'b1;
				if (out_col_q + 1'b1 >= n_c) begin
					out_col_q  <= '0;
					out_slot_q <= (out_slot_q == SLOT_W'(LINE_SLOTS - 1)) ? '0 : out_slot_q + 1'b1;
					if (out_row_q + 1'b1 >= n_c) begin
						out_row_q <= '0;
						out_idx_q <= '0;
					end else begin
						out_row_q <= out_row_q + 1'b1;
						out_idx_q <= out_idx_q + 1'b1;
					end
				end else begin
					out_col_q <= out_col_q + 1'b1;
					out_idx_q <= out_idx_q + 1'b1;
				end
			end
		end
	end

	// tap address
	localparam int RC_W = POS_W + 2;
	logic signed [RC_W-1:0] tap_r, tap_c;
	logic [SLOT_W+1:0]      slot_raw, tap_slot;
	logic                   tap_in;
	always_comb begin
		tap_r = $signed({2'b00, out_row_q}) + $signed(RC_W'(k_q)) - $signed(RC_W'(BACK));
		tap_c = $signed({2'b00, out_col_q}) + $signed(RC_W'(l_q)) - $signed(RC_W'(BACK));
		tap_in = (tap_r >= 0) && (tap_r < $signed({2'b00, n_c}))
		      && (tap_c >= 0) && (tap_c < $signed({2'b00, n_c}));
		slot_raw = (SLOT_W+2)'(out_slot_q) + (SLOT_W+2)'(LINE_SLOTS) + (SLOT_W+2)'(k_q)
		         - (SLOT_W+2)'(BACK);
		if (slot_raw >= (SLOT_W+2)'(2 * LINE_SLOTS)) tap_slot = slot_raw - (SLOT_W+2)'(2 * LINE_SLOTS);
		else if (slot_raw >= (SLOT_W+2)'(LINE_SLOTS)) tap_slot = slot_raw - (SLOT_W+2)'(LINE_SLOTS);
		else tap_slot = slot_raw;
	end

	// line store ports
	always_comb begin
		ram_we = smp_acc;
		waddr  = ADDR_W'(in_slot_q) * ADDR_W'(MAX_SIZE) + ADDR_W'(in_col_q);
		if (cmd.tap_rd)
			raddr = ADDR_W'(tap_slot) * ADDR_W'(MAX_SIZE) + ADDR_W'(tap_c[POS_W-1:0]);
		else
			raddr = ADDR_W'(out_slot_q) * ADDR_W'(MAX_SIZE) + ADDR_W'(out_col_q);
	end

	nmc_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	// centre check
	logic in_rng;
	logic skip_c;
	always_comb begin
		in_rng = (lower_q <= rdata) && (rdata < upper_q);
		skip_c = ((mode_q == MODE_ZERO) || (mode_q == MODE_PASS)) && !in_rng;
	end

	// weight select
	logic [COEF_WORDS*CFG_W-1:0] coef_flat;
	assign coef_flat = {coef_q[3], coef_q[2], coef_q[1], coef_q[0]};

	logic signed [SAMPLE_W+WEIGHT_W:0] prod;
	assign prod = rdata * $signed({1'b0, tap_w_q});

	logic [WSUM_W:0] shifted;
	assign shifted = {rem_q[WSUM_W-1:0], mag_q[ACC_W-1]};

	// window accumulation and restoring divider
	always_ff @(posedge clk) begin
		if (cmd.rd_ctr) begin
			k_q    <= '0;
			l_q    <= '0;
			t_q    <= '0;
			acc_q  <= '0;
			wsum_q <= '0;
		end
		if (cmd.chk_ctr) begin
			centre_q <= rdata;
			skip_q   <= skip_c;
		end
		if (cmd.tap_rd) begin
			tap_ok_q <= tap_in;
			tap_w_q  <= coef_flat[t_q*WEIGHT_W +: WEIGHT_W];
		end
		if (cmd.tap_acc) begin
			if (tap_ok_q) begin
				acc_q  <= acc_q + ACC_W'(prod);
				wsum_q <= wsum_q + WSUM_W'(tap_w_q);
			end
			t_q <= t_q + 1'b1;
			if (l_q == KIDX_W'(KERNEL_SIZE - 1)) begin
				l_q <= '0;
				k_q <= k_q + 1'b1;
			end else begin
				l_q <= l_q + 1'b1;
			end
		end
		if (cmd.div_start) begin
			mag_q  <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
			neg_q  <= acc_q[ACC_W-1];
			rem_q  <= '0;
			divc_q <= '0;
		end
		if (cmd.div_step) begin
			divc_q <= divc_q + 1'b1;
			if (shifted >= {1'b0, wsum_q}) begin
				rem_q <= shifted - {1'b0, wsum_q};
				mag_q <= {mag_q[ACC_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				mag_q <= {mag_q[ACC_W-2:0], 1'b0};
			end
		end
	end

	// output register
	logic [ACC_W-1:0] quot;
	assign quot = neg_q ? -mag_q : mag_q;

	// status back to the sequencer
	assign stat = '{
		emit_req: emit_req_c,
		skip:     skip_c,
		tap_last: (t_q == TAP_W'(TAPS - 1)),
		div_last: (divc_q == DIVC_W'(ACC_W - 1)),
		out_free: (!out_valid || out_ready)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			last_pixel <= (out_row_q == n_c - 1'b1) && (out_col_q == n_c - 1'b1);
			if (skip_q) begin
				result    <= (mode_q == MODE_PASS) ? centre_q : '0;
				no_weight <= 1'b0;
			end else if (wsum_q == '0) begin
				result    <= '0;
				no_weight <= 1'b1;
			end else begin
				result    <= quot[SAMPLE_W-1:0];
				no_weight <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/nmc_checker.sv @@
// port-level checker for the convolution top level, with its bind
`default_nettype none
module nmc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] result,
	input wire logic        no_weight,
	input wire logic        last_pixel
);
	// held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result) && $stable(no_weight)
		&& $stable(last_pixel))
		else $error("result beat changed while stalled");

	// a result flagged no_weight is always zero
	a_no_weight_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_weight |-> result == 16'd0)
		else $error("no_weight set with nonzero result");

	// nothing is offered while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("out_valid during reset");

	// a fresh result never appears in the cycle right after an input beat is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");
endmodule

bind normalized_masked_convolution nmc_checker u_nmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.result     (result),
	.no_weight  (no_weight),
	.last_pixel (last_pixel)
);
`default_nettype wire
